### rtl/core/pxscale_pkg.sv
package pxscale_pkg;

	// default pixel width and fixed port field widths
	localparam int PIX_BITS_DEF = 32;
	localparam int FIELD_BITS   = 32;
	localparam int FLAG_BITS    = 4;
	localparam int SCALE_BITS   = 2;
	localparam int WIN_PIX      = 9;
	localparam int CELL_PIX     = 9;

	// edge flag bit positions
	localparam int FLAG_LEFT   = 0;
	localparam int FLAG_RIGHT  = 1;
	localparam int FLAG_TOP    = 2;
	localparam int FLAG_BOTTOM = 3;

	// scale register code that selects the 3x3 block, and the reset code
	localparam logic [SCALE_BITS-1:0] SCALE_X3    = 2'd3;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 2'd2;

	typedef struct packed {
		logic [FIELD_BITS-1:0] up_left;
		logic [FIELD_BITS-1:0] up_mid;
		logic [FIELD_BITS-1:0] up_right;
		logic [FIELD_BITS-1:0] mid_left;
		logic [FIELD_BITS-1:0] center_pixel;
		logic [FIELD_BITS-1:0] mid_right;
		logic [FIELD_BITS-1:0] down_left;
		logic [FIELD_BITS-1:0] down_mid;
		logic [FIELD_BITS-1:0] down_right;
		logic [FLAG_BITS-1:0]  edge_flags;
	} pix_in_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] cell_0;
		logic [FIELD_BITS-1:0] cell_1;
		logic [FIELD_BITS-1:0] cell_2;
		logic [FIELD_BITS-1:0] cell_3;
		logic [FIELD_BITS-1:0] cell_4;
		logic [FIELD_BITS-1:0] cell_5;
		logic [FIELD_BITS-1:0] cell_6;
		logic [FIELD_BITS-1:0] cell_7;
		logic [FIELD_BITS-1:0] cell_8;
	} pix_out_t;

endpackage

### rtl/core/pixel_art_scale2x_scale3x.sv
// channel  direction  handshake           payload
// src      in         src_valid/src_stall pxscale_pkg::pix_in_t  (3x3 window + edge flags)
// dst      out        dst_valid/dst_stall pxscale_pkg::pix_out_t (up to nine output cells)
// cfg      in         cfg_valid/cfg_ready cfg_data, scale factor (3 = 3x3, else 2x2)
//
// one item per clock sustained while dst does not stall; an accepted src item is
// held in the input register, then in the result register that drives dst_valid
// the path is input register -> window clamp and pixel compares -> result register
// arst_n clears the valid bits and sets the scale back to 2x2
// a stalled dst holds the result register; src_stall rises only once the input
// register is also full and cannot move forward
module pixel_art_scale2x_scale3x #(
	parameter int PIXEL_BITS = pxscale_pkg::PIX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               src_valid,
	output logic                               src_stall,
	input  pxscale_pkg::pix_in_t               src,
	output logic                               dst_valid,
	input  logic                               dst_stall,
	output pxscale_pkg::pix_out_t              dst,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pxscale_pkg::SCALE_BITS-1:0] cfg_data
);
	import pxscale_pkg::*;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	// scale register, only the 3x3 choice matters
	logic sel3_q;

	// input register
	logic                 valid_s1;
	pix_t                 win_s1 [WIN_PIX];
	logic [FLAG_BITS-1:0] flags_s1;
	pix_t                 win_d [WIN_PIX];

	// result register
	logic valid_s2;
	pix_t cells_s2 [CELL_PIX];
	pix_t cells_d [CELL_PIX];

	logic s2_ready;
	logic s1_ready;

	// config is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel3_q <= (SCALE_RESET == SCALE_X3);
		end else if (cfg_valid && cfg_ready) begin
			sel3_q <= (cfg_data == SCALE_X3);
		end
	end

	// stage flow: a stage moves when it is empty or the next one takes its item
	assign s2_ready  = !valid_s2 || !dst_stall;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign src_stall = !s1_ready;

	// bits above PIXEL_BITS are dropped at the input register
	assign win_d[0] = src.up_left[PIXEL_BITS-1:0];
	assign win_d[1] = src.up_mid[PIXEL_BITS-1:0];
	assign win_d[2] = src.up_right[PIXEL_BITS-1:0];
	assign win_d[3] = src.mid_left[PIXEL_BITS-1:0];
	assign win_d[4] = src.center_pixel[PIXEL_BITS-1:0];
	assign win_d[5] = src.mid_right[PIXEL_BITS-1:0];
	assign win_d[6] = src.down_left[PIXEL_BITS-1:0];
	assign win_d[7] = src.down_mid[PIXEL_BITS-1:0];
	assign win_d[8] = src.down_right[PIXEL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && src_valid) begin
			win_s1   <= win_d;
			flags_s1 <= src.edge_flags;
		end
	end

	// clamp and scale2x / scale3x rule
	pxscale_kernel #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_kernel (
		.win   (win_s1),
		.flags (flags_s1),
		.sel3  (sel3_q),
		.cells (cells_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			cells_s2 <= cells_d;
		end
	end

	// zero extend each cell onto the fixed width port
	assign dst_valid  = valid_s2;
	assign dst.cell_0 = FIELD_BITS'(cells_s2[0]);
	assign dst.cell_1 = FIELD_BITS'(cells_s2[1]);
	assign dst.cell_2 = FIELD_BITS'(cells_s2[2]);
	assign dst.cell_3 = FIELD_BITS'(cells_s2[3]);
	assign dst.cell_4 = FIELD_BITS'(cells_s2[4]);
	assign dst.cell_5 = FIELD_BITS'(cells_s2[5]);
	assign dst.cell_6 = FIELD_BITS'(cells_s2[6]);
	assign dst.cell_7 = FIELD_BITS'(cells_s2[7]);
	assign dst.cell_8 = FIELD_BITS'(cells_s2[8]);

	// back pressure only when the input register holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1)
		else $error("src stalled with empty input register");

	// an item in the input register is kept until it moves on
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_ready) |=> valid_s1)
		else $error("item lost from input register");

	// an item that moves on lands in the result register
	a_s2_load: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && s2_ready) |=> valid_s2)
		else $error("item not loaded into result register");

endmodule

### rtl/core/pxscale_kernel.sv
module pxscale_kernel #(
	parameter int PIXEL_BITS = pxscale_pkg::PIX_BITS_DEF
) (
	input  logic [PIXEL_BITS-1:0]              win [pxscale_pkg::WIN_PIX],
	input  logic [pxscale_pkg::FLAG_BITS-1:0]  flags,
	input  logic                               sel3,
	output logic [PIXEL_BITS-1:0]              cells [pxscale_pkg::CELL_PIX]
);
	import pxscale_pkg::*;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	pix_t r0 [3];
	pix_t r2 [3];
	pix_t a, b, c, d, e, f, g, h, i;
	pix_t e0, e1, e2, e3, e4, e5, e6, e7;

	function automatic pix_t corner_pick(pix_t p, pix_t q, pix_t r, pix_t s, pix_t ctr);
		return (p == q && p != r && q != s) ? p : ctr;
	endfunction

	// row clamp first, then column clamp
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r0[k] = flags[FLAG_TOP]    ? win[3 + k] : win[k];
			r2[k] = flags[FLAG_BOTTOM] ? win[3 + k] : win[6 + k];
		end
	end

	assign a = flags[FLAG_LEFT]  ? r0[1]  : r0[0];
	assign b = r0[1];
	assign c = flags[FLAG_RIGHT] ? r0[1]  : r0[2];
	assign d = flags[FLAG_LEFT]  ? win[4] : win[3];
	assign e = win[4];
	assign f = flags[FLAG_RIGHT] ? win[4] : win[5];
	assign g = flags[FLAG_LEFT]  ? r2[1]  : r2[0];
	assign h = r2[1];
	assign i = flags[FLAG_RIGHT] ? r2[1]  : r2[2];

	// scale2x corners
	assign e0 = corner_pick(d, b, h, f, e);
	assign e1 = corner_pick(f, b, h, d, e);
	assign e2 = corner_pick(d, h, b, f, e);
	assign e3 = corner_pick(f, h, b, d, e);

	// side middles follow a diagonal
	assign e4 = (e0 == c) ? e0 : (e1 == a) ? e1 : e;
	assign e5 = (e2 == a) ? e2 : (e0 == g) ? e0 : e;
	assign e6 = (e1 == i) ? e1 : (e3 == c) ? e3 : e;
	assign e7 = (e3 == g) ? e3 : (e2 == i) ? e2 : e;

	always_comb begin
		if (sel3) begin
			cells[0] = e0; cells[1] = e4; cells[2] = e1;
			cells[3] = e5; cells[4] = e;  cells[5] = e6;
			cells[6] = e2; cells[7] = e7; cells[8] = e3;
		end else begin
			cells[0] = e0; cells[1] = e1; cells[2] = e2; cells[3] = e3;
			for (int k = 4; k < CELL_PIX; k++) begin
				cells[k] = '0;
			end
		end
	end

endmodule
